[rtl/rwl_pkg.sv]
`timescale 1ns / 1ps

package rwl_pkg;

	// fixed widths of the channel fields
	localparam int IDX_W     = 10;
	localparam int CMD_W     = 2;
	localparam int GRANT_W   = 2;
	localparam int OUT_CNT_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_W_ACQ = 2'd0,
		CMD_R_ACQ = 2'd1,
		CMD_W_REL = 2'd2,
		CMD_R_REL = 2'd3
	} cmd_t;

	typedef enum logic [GRANT_W-1:0] {
		GRANT_NONE  = 2'd0,
		GRANT_ONE_W = 2'd1,
		GRANT_ALL_R = 2'd2
	} grant_t;

	// classified command as it waits between front and back
	typedef struct packed {
		cmd_t             cmd;
		logic             in_range;
		logic [IDX_W-1:0] idx;
	} cmd_item_t;

endpackage

[rtl/rwl_req_if.sv]
`timescale 1ns / 1ps

interface rwl_req_if import rwl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [IDX_W-1:0] lock_index;

	modport source (output valid, output command, output lock_index, input ready);
	modport sink (input valid, input command, input lock_index, output ready);
endinterface

[rtl/rwl_rsp_if.sv]
`timescale 1ns / 1ps

interface rwl_rsp_if import rwl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [GRANT_W-1:0]   grant;
	logic                 count_error;
	logic [OUT_CNT_W-1:0] writers_after;
	logic [OUT_CNT_W-1:0] readers_after;

	modport source (
		output valid, output grant, output count_error,
		output writers_after, output readers_after, input ready
	);
	modport sink (
		input valid, input grant, input count_error,
		input writers_after, input readers_after, output ready
	);
endinterface

[rtl/rwl_ram.sv]
`timescale 1ns / 1ps

module rwl_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port, registered read port (read returns the old word on a collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/rwl_front.sv]
`timescale 1ns / 1ps

module rwl_front import rwl_pkg::*; #(
	parameter int LOCK_ENTRIES = 1024
) (
	rwl_req_if.sink   req,
	input  logic      clearing,
	output logic      push_valid,
	input  logic      push_ready,
	output cmd_item_t push_item
);

	// hold off transfers while the table is being cleared
	assign req.ready  = push_ready && !clearing;
	assign push_valid = req.valid && !clearing;

	// classify: decode the command and flag indexes beyond the table
	always_comb begin
		push_item.cmd      = cmd_t'(req.command);
		push_item.idx      = req.lock_index;
		push_item.in_range = (32'(req.lock_index) < LOCK_ENTRIES);
	end

endmodule

[rtl/rwl_queue.sv]
`timescale 1ns / 1ps

module rwl_queue import rwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  cmd_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output cmd_item_t pop_item
);

	cmd_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/rwl_back.sv]
`timescale 1ns / 1ps

module rwl_back import rwl_pkg::*; #(
	parameter int LOCK_ENTRIES = 1024,
	parameter int COUNT_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  cmd_item_t pop_item,
	output logic      clearing,
	rwl_rsp_if.source rsp
);

	localparam int DEPTH  = (LOCK_ENTRIES < (1 << IDX_W)) ? LOCK_ENTRIES : (1 << IDX_W);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WORD_W = 2 * COUNT_BITS + 1;
	localparam int EXT_W  = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// clearing sweep
	logic              clear_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// issue stage: item whose table word is in the read register
	logic              s1_valid_q;
	cmd_item_t         s1_item_q;
	logic [ADDR_W-1:0] s1_addr;
	logic              s1_fire;

	// last word written, forwarded to a following access of the same lock
	logic              wb_valid_q;
	logic [ADDR_W-1:0] wb_addr_q;
	logic [WORD_W-1:0] wb_word_q;

	// result register
	logic                 rsp_valid_q;
	grant_t               rsp_grant_q;
	logic                 rsp_err_q;
	logic [OUT_CNT_W-1:0] rsp_w_q;
	logic [OUT_CNT_W-1:0] rsp_r_q;

	// memory ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	// update datapath
	logic [WORD_W-1:0]     cur_word;
	logic [WORD_W-1:0]     new_word;
	logic [COUNT_BITS-1:0] w;
	logic [COUNT_BITS-1:0] r;
	logic                  ph;
	grant_t                g;
	logic                  err;
	logic [EXT_W-1:0]      w_ext;
	logic [EXT_W-1:0]      r_ext;

	assign clearing  = clear_q;
	assign s1_addr   = s1_item_q.idx[ADDR_W-1:0];
	assign s1_fire   = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign pop_ready = !clear_q && (!s1_valid_q || s1_fire);

	rwl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop_valid && pop_ready),
		.raddr (pop_item.idx[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// pick the freshest copy of the lock word
	assign cur_word = (wb_valid_q && (wb_addr_q == s1_addr)) ? wb_word_q : ram_rdata;

	// apply the arbiter rules to one lock word
	always_comb begin
		ph  = cur_word[WORD_W-1];
		w   = cur_word[2*COUNT_BITS-1:COUNT_BITS];
		r   = cur_word[COUNT_BITS-1:0];
		g   = GRANT_NONE;
		err = 1'b0;
		unique case (s1_item_q.cmd)
			CMD_W_ACQ: begin
				if (w == COUNT_MAX) begin
					err = 1'b1;
				end else begin
					if (w == '0 && r == '0) begin
						g = GRANT_ONE_W;
					end else if (w == '0) begin
						ph = 1'b1;
					end
					w = w + 1'b1;
				end
			end
			CMD_R_ACQ: begin
				if (r == COUNT_MAX) begin
					err = 1'b1;
				end else begin
					if (w == '0) begin
						g  = GRANT_ALL_R;
						ph = 1'b1;
					end else if (ph && r != '0) begin
						g = GRANT_ALL_R;
					end else begin
						ph = 1'b0;
					end
					r = r + 1'b1;
				end
			end
			CMD_W_REL: begin
				if (w == '0) begin
					err = 1'b1;
				end else begin
					w = w - 1'b1;
					if (w != '0) begin
						g = GRANT_ONE_W;
					end else if (r != '0) begin
						g  = GRANT_ALL_R;
						ph = 1'b1;
					end
				end
			end
			CMD_R_REL: begin
				if (r == '0) begin
					err = 1'b1;
				end else begin
					r = r - 1'b1;
					if (r == '0 && w != '0) begin
						g  = GRANT_ONE_W;
						ph = 1'b0;
					end
				end
			end
			default: begin
				err = 1'b0;
			end
		endcase
		// drop the phase once either side is empty
		if (w == '0 || r == '0) begin
			ph = 1'b0;
		end
		new_word = {ph, w, r};
		w_ext    = EXT_W'(w);
		r_ext    = EXT_W'(r);
	end

	// write back the update, or zero during the sweep
	always_comb begin
		if (clear_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_fire && s1_item_q.in_range;
			ram_waddr = s1_addr;
			ram_wdata = new_word;
		end
	end

	// load the result payload, the issue-stage item and the forwarded word
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			if (s1_item_q.in_range) begin
				rsp_grant_q <= g;
				rsp_err_q   <= err;
				rsp_w_q     <= w_ext[OUT_CNT_W-1:0];
				rsp_r_q     <= r_ext[OUT_CNT_W-1:0];
			end else begin
				rsp_grant_q <= GRANT_NONE;
				rsp_err_q   <= 1'b0;
				rsp_w_q     <= '0;
				rsp_r_q     <= '0;
			end
		end
		if (pop_valid && pop_ready) begin
			s1_item_q <= pop_item;
		end
		if (ram_we && !clear_q) begin
			wb_addr_q <= s1_addr;
			wb_word_q <= new_word;
		end
	end

	// sequence the sweep, issue stage and result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q     <= 1'b1;
			clr_addr_q  <= '0;
			s1_valid_q  <= 1'b0;
			wb_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clear_q) begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clear_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (pop_valid && pop_ready) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (ram_we && !clear_q) begin
				wb_valid_q <= 1'b1;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.grant         = rsp_grant_q;
	assign rsp.count_error   = rsp_err_q;
	assign rsp.writers_after = rsp_w_q;
	assign rsp.readers_after = rsp_r_q;

endmodule

[rtl/reader_writer_lock_home_arbiter.sv]
`timescale 1ns / 1ps

// Reader-writer lock home arbiter.
// req channel: one transfer carries a command (writer/reader acquire or release)
// and the index of the lock it applies to. rsp channel: one transfer per command
// with the grant code, an over/underflow flag and the lock's counts afterwards.
// Results leave in command order.
// Each command passes the queue, the table read and the update into the result
// register, in that order.
// Throughput: one command per cycle while rsp is taken, set by the single
// read-modify-write of the lock table per command; the last written word is
// forwarded so that commands to the same lock may follow each other directly.
// Reset: the lock table is swept to zero, one entry a cycle, over
// min(LOCK_ENTRIES, 1024) entries; req.ready stays low until the sweep is done.
// Stall: when rsp is not taken the result register holds, the back end stops,
// and a two-entry queue keeps taking commands until it fills, after which
// req.ready drops.
module reader_writer_lock_home_arbiter import rwl_pkg::*; #(
	parameter int LOCK_ENTRIES = 1024,
	parameter int COUNT_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rwl_req_if.sink   req,
	rwl_rsp_if.source rsp
);

	logic      clearing;
	logic      push_valid;
	logic      push_ready;
	cmd_item_t push_item;
	logic      pop_valid;
	logic      pop_ready;
	cmd_item_t pop_item;

	rwl_front #(
		.LOCK_ENTRIES (LOCK_ENTRIES)
	) u_front (
		.req        (req),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	rwl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	rwl_back #(
		.LOCK_ENTRIES (LOCK_ENTRIES),
		.COUNT_BITS   (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule
